FILE: hw/rtl/balu_pkg.sv
package balu_pkg;

    typedef enum logic [3:0] {
        ACT_ADD = 4'd0,
        ACT_SUB = 4'd1,
        ACT_AND = 4'd2,
        ACT_OR  = 4'd3,
        ACT_NOT = 4'd4,
        ACT_SHL = 4'd5,
        ACT_SHR = 4'd6,
        ACT_MUL = 4'd7,
        ACT_DIV = 4'd8,
        ACT_MOD = 4'd9
    } action_t;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned NUM_CELLS = BYTE_W;

    // Item as it moves down the cell chain
    typedef struct packed {
        action_t               action;
        logic [2*BYTE_W-1:0]   mcand;      // multiplicand, shifted left per cell
        logic [BYTE_W-1:0]     mplier;     // multiplier, shifted right per cell
        logic [2*BYTE_W-1:0]   prod;       // partial product
        logic [BYTE_W-1:0]     dvd;        // dividend, shifted left per cell
        logic [BYTE_W-1:0]     dvs;        // divisor
        logic [BYTE_W-1:0]     rem;        // partial remainder
        logic [BYTE_W-1:0]     quo;        // quotient bits so far
        logic [BYTE_W-1:0]     simple_lo;  // result of the simple (non-multiply, non-divide) operations
        logic                  cout;
        logic                  sgt;
        logic                  eq;
    } work_t;

endpackage

FILE: hw/rtl/balu_cell.sv
module balu_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  balu_pkg::work_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output balu_pkg::work_t  out_data
);
    import balu_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    work_t               data_reg;
    work_t               data_next;
    logic [BYTE_W:0]     trial;
    logic                fits;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // one restoring-divide step and one shift-add multiply step
    always_comb begin
        trial = {in_data.rem, in_data.dvd[BYTE_W-1]};
        fits  = (trial >= {1'b0, in_data.dvs});

        data_next        = in_data;
        data_next.prod   = in_data.mplier[0] ? (in_data.prod + in_data.mcand) : in_data.prod;
        data_next.mcand  = {in_data.mcand[2*BYTE_W-2:0], 1'b0};
        data_next.mplier = {1'b0, in_data.mplier[BYTE_W-1:1]};
        data_next.dvd    = {in_data.dvd[BYTE_W-2:0], 1'b0};
        data_next.rem    = fits ? BYTE_W'(trial - {1'b0, in_data.dvs}) : trial[BYTE_W-1:0];
        data_next.quo    = {in_data.quo[BYTE_W-2:0], fits};

        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: hw/rtl/byte_alu_with_mul_div.sv
// Byte ALU: add/subtract with carry, AND, OR, NOT, shifts, unsigned 8x8 multiply and
// unsigned divide/remainder, with signed-greater and equality flags on every item.
// Each item passes a chain of eight cells, each retiring one bit of the multiply and one
// bit of the divide, then an output register; one item is accepted every cycle while
// results are taken. Each stage holds on its own under back-pressure, so empty slots
// keep filling while a finished result waits to be taken. A zero divisor on divide or
// remainder gives zeros with divide_by_zero set; unused action codes give zero results.
module byte_alu_with_mul_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] action, [11:4] operand_a, [19:12] operand_b, [20] carry_in, [23:21] zero
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] result_low, [15:8] result_high, [16] carry_out, [17] signed_greater,
    // [18] operands_equal, [19] divide_by_zero, [23:20] zero
    output logic [23:0] m_tdata
);
    import balu_pkg::*;

    action_t             in_action;
    logic [BYTE_W-1:0]   in_a;
    logic [BYTE_W-1:0]   in_b;
    logic                in_cin;
    logic [BYTE_W:0]     sum;
    work_t               entry;

    logic                chain_valid [NUM_CELLS+1];
    logic                chain_ready [NUM_CELLS+1];
    work_t               chain_data  [NUM_CELLS+1];

    work_t               last;
    logic                out_load;
    logic [BYTE_W-1:0]   res_lo;
    logic [BYTE_W-1:0]   res_hi;
    logic                res_dz;

    logic                m_valid_reg;
    logic [23:0]         m_data_reg;

    assign in_action = action_t'(s_tdata[3:0]);
    assign in_a      = s_tdata[11:4];
    assign in_b      = s_tdata[19:12];
    assign in_cin    = s_tdata[20];

    // simple operations are settled at entry and carried along
    always_comb begin
        sum = '0;
        entry = '0;
        entry.action = in_action;
        entry.mcand  = {{BYTE_W{1'b0}}, in_a};
        entry.mplier = in_b;
        entry.dvd    = in_a;
        entry.dvs    = in_b;
        entry.sgt    = $signed(in_a) > $signed(in_b);
        entry.eq     = (in_a == in_b);
        case (in_action)
            ACT_ADD: begin
                sum = {1'b0, in_a} + {1'b0, in_b} + {{BYTE_W{1'b0}}, in_cin};
                entry.simple_lo = sum[BYTE_W-1:0];
                entry.cout      = sum[BYTE_W];
            end
            ACT_SUB: begin
                sum = {1'b0, in_a} + {1'b0, ~in_b} + {{BYTE_W{1'b0}}, in_cin};
                entry.simple_lo = sum[BYTE_W-1:0];
                entry.cout      = sum[BYTE_W];
            end
            ACT_AND: entry.simple_lo = in_a & in_b;
            ACT_OR:  entry.simple_lo = in_a | in_b;
            ACT_NOT: entry.simple_lo = ~in_a;
            ACT_SHL: entry.simple_lo = (in_b >= 8'd8) ? '0 : (in_a << in_b[2:0]);
            ACT_SHR: entry.simple_lo = (in_b >= 8'd8) ? '0 : (in_a >> in_b[2:0]);
            default: entry.simple_lo = '0;
        endcase
    end

    assign chain_valid[0] = s_tvalid;
    assign chain_data[0]  = entry;
    assign s_tready       = chain_ready[0];

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        balu_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    assign last                   = chain_data[NUM_CELLS];
    assign chain_ready[NUM_CELLS] = !m_valid_reg || m_tready;
    assign out_load               = chain_valid[NUM_CELLS] && chain_ready[NUM_CELLS];

    always_comb begin
        res_lo = last.simple_lo;
        res_hi = '0;
        res_dz = 1'b0;
        case (last.action)
            ACT_MUL: begin
                res_lo = last.prod[BYTE_W-1:0];
                res_hi = last.prod[2*BYTE_W-1:BYTE_W];
            end
            ACT_DIV: begin
                res_dz = (last.dvs == '0);
                res_lo = res_dz ? '0 : last.quo;
            end
            ACT_MOD: begin
                res_dz = (last.dvs == '0);
                res_lo = res_dz ? '0 : last.rem;
            end
            default: res_lo = last.simple_lo;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (chain_ready[NUM_CELLS]) begin
            m_valid_reg <= chain_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {4'b0, res_dz, last.eq, last.sgt, last.cout, res_hi, res_lo};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
